// ===== src/glc_pkg.sv =====
`timescale 1ns / 1ps

package glc_pkg;

    localparam int NODES      = 16;
    localparam int IDX_W      = $clog2(NODES);
    localparam int CNT_W      = $clog2(NODES + 1);
    localparam int ROW_W      = 16;
    localparam int LBL_W      = 5;
    localparam int NIDX_W     = 4;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam logic [LBL_W-1:0] MAX_LABELS_RST = LBL_W'(4);

    typedef logic [NODES:0] t_lmask;

    // microprogram steps, one-hot
    typedef enum logic [8:0] {
        ST_LOAD    = 9'b000000001,
        ST_INIT    = 9'b000000010,
        ST_NODE    = 9'b000000100,
        ST_SCAN    = 9'b000001000,
        ST_PICK    = 9'b000010000,
        ST_FAIL    = 9'b000100000,
        ST_EM_SHOW = 9'b001000000,
        ST_EM_WAIT = 9'b010000000,
        ST_EM_NEXT = 9'b100000000
    } t_step;

    // branch conditions
    typedef enum logic [2:0] {
        C_ALWAYS    = 3'd0,
        C_IN_LAST   = 3'd1,
        C_IDX_DONE  = 3'd2,
        C_SCAN_DONE = 3'd3,
        C_NO_FAIL   = 3'd4,
        C_OUT_TAKEN = 3'd5,
        C_SENT_LAST = 3'd6
    } t_cond;

    // datapath operations of one step
    typedef struct packed {
        logic in_rdy;
        logic init;
        logic node_start;
        logic scan;
        logic pick;
        logic fail;
        logic show;
        logic k_inc;
    } t_ctrl;

    typedef struct packed {
        t_ctrl ops;
        t_cond cond;
        t_step br;
        t_step nxt;
    } t_uword;

    typedef struct packed {
        logic in_last;
        logic idx_done;
        logic scan_done;
        logic fail;
        logic out_taken;
        logic sent_last;
    } t_status;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{ops: '0, cond: C_ALWAYS, br: ST_LOAD, nxt: ST_LOAD};
        unique case (step)
            ST_LOAD: begin
                w.ops.in_rdy = 1'b1;
                w.cond = C_IN_LAST;   w.br = ST_INIT;    w.nxt = ST_LOAD;
            end
            ST_INIT: begin
                w.ops.init = 1'b1;
                w.cond = C_ALWAYS;    w.br = ST_NODE;    w.nxt = ST_NODE;
            end
            ST_NODE: begin
                w.ops.node_start = 1'b1;
                w.cond = C_IDX_DONE;  w.br = ST_EM_SHOW; w.nxt = ST_SCAN;
            end
            ST_SCAN: begin
                w.ops.scan = 1'b1;
                w.cond = C_SCAN_DONE; w.br = ST_PICK;    w.nxt = ST_SCAN;
            end
            ST_PICK: begin
                w.ops.pick = 1'b1;
                w.cond = C_NO_FAIL;   w.br = ST_NODE;    w.nxt = ST_FAIL;
            end
            ST_FAIL: begin
                w.ops.fail = 1'b1;
                w.cond = C_ALWAYS;    w.br = ST_EM_WAIT; w.nxt = ST_EM_WAIT;
            end
            ST_EM_SHOW: begin
                w.ops.show = 1'b1;
                w.cond = C_ALWAYS;    w.br = ST_EM_WAIT; w.nxt = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                w.cond = C_OUT_TAKEN; w.br = ST_EM_NEXT; w.nxt = ST_EM_WAIT;
            end
            ST_EM_NEXT: begin
                w.ops.k_inc = 1'b1;
                w.cond = C_SENT_LAST; w.br = ST_LOAD;    w.nxt = ST_EM_SHOW;
            end
            default: begin
                w.cond = C_ALWAYS;    w.br = ST_LOAD;    w.nxt = ST_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/greedy_conflict_labeler.sv =====
`timescale 1ns / 1ps

// Channel   | Dir | Handshake                       | Payload
// s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tdata[15:0] row_mask, tlast last_row
// m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata node_index, node_label;
//           |     |                                 | tuser no_solution, tlast last_result
// cfg       | in  | i_cfg_valid/o_cfg_ready         | i_cfg_data[4:0] max_labels
//
// Loading accepts one row word per cycle. After the row marked last, node i of
// the run passes the sequencer steps start, scan of its i earlier labels
// through the registered-read label store, and pick. Each result word then
// passes the show (or fail), wait and next steps, the wait held by any stall on
// m_axis; a failed run gives one word. Rows are refused while labeling or emitting.
// Reset is synchronous: back to row loading, max_labels to 4, stores untouched.

module greedy_conflict_labeler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [glc_pkg::S_TDATA_W-1:0] i_s_axis_tdata,   // [15:0] row_mask
    input  logic                          i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [glc_pkg::M_TDATA_W-1:0] o_m_axis_tdata,   // [3:0] node_index, [8:4] node_label
    output logic                          o_m_axis_tlast,
    output logic [0:0]                    o_m_axis_tuser,   // [0] no_solution
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [glc_pkg::LBL_W-1:0]     i_cfg_data
);

    glc_pkg::t_ctrl   w_ctrl;
    glc_pkg::t_status w_status;

    // microprogram sequencer: step register, control ROM, branch select
    glc_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // datapath: row and label stores, counters, free-label pick, output word
    glc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_ctrl          (w_ctrl),
        .o_status        (w_status)
    );

endmodule

// ===== src/glc_useq.sv =====
`timescale 1ns / 1ps

module glc_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  glc_pkg::t_status i_status,
    output glc_pkg::t_ctrl   o_ctrl
);

    glc_pkg::t_step  r_step;
    glc_pkg::t_step  n_step;
    glc_pkg::t_uword w_word;
    logic            w_take;

    assign w_word = glc_pkg::ucode(r_step);
    assign o_ctrl = w_word.ops;

    always_comb begin
        unique case (w_word.cond)
            glc_pkg::C_ALWAYS:    w_take = 1'b1;
            glc_pkg::C_IN_LAST:   w_take = i_status.in_last;
            glc_pkg::C_IDX_DONE:  w_take = i_status.idx_done;
            glc_pkg::C_SCAN_DONE: w_take = i_status.scan_done;
            glc_pkg::C_NO_FAIL:   w_take = !i_status.fail;
            glc_pkg::C_OUT_TAKEN: w_take = i_status.out_taken;
            glc_pkg::C_SENT_LAST: w_take = i_status.sent_last;
            default:              w_take = 1'b1;
        endcase
        n_step = w_take ? w_word.br : w_word.nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= glc_pkg::ST_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

    a_step_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_step))
        else $error("step register lost one-hot form");

endmodule

// ===== src/glc_dpath.sv =====
`timescale 1ns / 1ps

module glc_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [glc_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [glc_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    output logic [0:0]                        o_m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [glc_pkg::LBL_W-1:0]         i_cfg_data,
    input  glc_pkg::t_ctrl                    i_ctrl,
    output glc_pkg::t_status                  o_status
);

    // storage
    logic [glc_pkg::ROW_W-1:0]  r_rows [glc_pkg::NODES];
    logic [glc_pkg::LBL_W-1:0]  r_lbls [glc_pkg::NODES];
    logic [glc_pkg::ROW_W-1:0]  r_row0;
    logic [glc_pkg::ROW_W-1:0]  r_row_q;
    logic [glc_pkg::LBL_W-1:0]  r_lab_q;

    // control registers
    logic [glc_pkg::LBL_W-1:0]  r_max;
    logic [glc_pkg::CNT_W-1:0]  r_loaded;
    logic [glc_pkg::CNT_W-1:0]  r_n;
    logic [glc_pkg::CNT_W-1:0]  r_i;
    logic [glc_pkg::CNT_W-1:0]  r_k;
    logic [glc_pkg::CNT_W-1:0]  n_k;
    logic [glc_pkg::LBL_W-1:0]  r_fresh;
    glc_pkg::t_lmask            r_taken;

    // output register
    logic                       r_m_valid;
    logic [glc_pkg::NIDX_W-1:0] r_m_idx;
    logic [glc_pkg::LBL_W-1:0]  r_m_lbl;
    logic                       r_m_nosol;
    logic                       r_m_last;

    logic                       w_s_acc;
    logic                       w_room;
    logic                       w_scan_done;
    logic                       w_scan_upd;
    logic [glc_pkg::LBL_W-1:0]  w_pick;
    logic                       w_fail;

    assign o_s_axis_tready = i_ctrl.in_rdy;
    assign o_cfg_ready     = 1'b1;
    assign w_s_acc         = i_s_axis_tvalid && i_ctrl.in_rdy;
    assign w_room          = (r_loaded < glc_pkg::CNT_W'(glc_pkg::NODES));
    assign w_scan_done     = (r_k == r_i);
    assign w_scan_upd      = i_ctrl.scan && !w_scan_done;

    // smallest free label below fresh, else fresh; row 0 forces fresh
    always_comb begin
        logic found;
        found  = 1'b0;
        w_pick = r_fresh;
        if (!r_row0[r_i[glc_pkg::IDX_W-1:0]]) begin
            for (int c = 1; c <= glc_pkg::NODES; c++) begin
                if (!found && (glc_pkg::LBL_W'(c) < r_fresh) && !r_taken[c]) begin
                    found  = 1'b1;
                    w_pick = glc_pkg::LBL_W'(c);
                end
            end
        end
    end

    assign w_fail = (w_pick == r_fresh) && (r_fresh > r_max);

    always_comb begin
        n_k = r_k;
        if (i_ctrl.node_start) begin
            n_k = '0;
        end else if (w_scan_upd || i_ctrl.k_inc) begin
            n_k = r_k + glc_pkg::CNT_W'(1);
        end
    end

    assign o_status = '{
        in_last:   w_s_acc && i_s_axis_tlast,
        idx_done:  (r_i == r_n),
        scan_done: w_scan_done,
        fail:      w_fail,
        out_taken: r_m_valid && i_m_axis_tready,
        sent_last: r_m_last
    };

    // row store and label store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (w_s_acc && w_room) begin
            r_rows[r_loaded[glc_pkg::IDX_W-1:0]] <= i_s_axis_tdata[glc_pkg::ROW_W-1:0];
        end
        if (i_ctrl.node_start) begin
            r_row_q <= r_rows[r_i[glc_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pick && !w_fail) begin
            r_lbls[r_i[glc_pkg::IDX_W-1:0]] <= w_pick;
        end
        r_lab_q <= r_lbls[n_k[glc_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc && (r_loaded == '0)) begin
            r_row0 <= i_s_axis_tdata[glc_pkg::ROW_W-1:0];
        end
        if (i_ctrl.node_start) begin
            r_taken <= '0;
        end else if (w_scan_upd && r_row_q[r_k[glc_pkg::IDX_W-1:0]]) begin
            r_taken <= r_taken | (glc_pkg::t_lmask'(1) << r_lab_q);
        end
        if (i_ctrl.show) begin
            r_m_idx   <= r_k[glc_pkg::NIDX_W-1:0];
            r_m_lbl   <= r_lab_q;
            r_m_nosol <= 1'b0;
            r_m_last  <= (r_k + glc_pkg::CNT_W'(1) == r_n);
        end else if (i_ctrl.fail) begin
            r_m_idx   <= '0;
            r_m_lbl   <= '0;
            r_m_nosol <= 1'b1;
            r_m_last  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= glc_pkg::MAX_LABELS_RST;
            r_loaded  <= '0;
            r_n       <= '0;
            r_i       <= '0;
            r_k       <= '0;
            r_fresh   <= glc_pkg::LBL_W'(1);
            r_m_valid <= 1'b0;
        end else begin
            r_k <= n_k;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (i_ctrl.init) begin
                r_n      <= r_loaded;
                r_loaded <= '0;
                r_i      <= '0;
                r_fresh  <= glc_pkg::LBL_W'(1);
            end else if (w_s_acc && w_room) begin
                r_loaded <= r_loaded + glc_pkg::CNT_W'(1);
            end
            if (i_ctrl.pick && !w_fail) begin
                r_i <= r_i + glc_pkg::CNT_W'(1);
                if (w_pick == r_fresh) begin
                    r_fresh <= r_fresh + glc_pkg::LBL_W'(1);
                end
            end
            if (i_ctrl.show || i_ctrl.fail) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = glc_pkg::M_TDATA_W'({r_m_lbl, r_m_idx});
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tuser  = r_m_nosol;

    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !i_ctrl.in_rdy)
        else $error("row word accepted while a result word waits");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan |-> (r_k <= r_i))
        else $error("scan index ran past current node");

    a_fresh_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh != '0)
        else $error("fresh label wrapped to zero");

    a_nosol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_nosol) |-> (r_m_last && r_m_lbl == '0))
        else $error("no-solution word must be the final word with label zero");

endmodule

// ===== dv/greedy_conflict_labeler_tb.sv =====
`timescale 1ns / 1ps

module greedy_conflict_labeler_tb;

    // cycles with no word moving on any channel before the run is called hung
    localparam int QUIET_LIMIT   = 4000;
    // cycles to let the sequencer return to row loading after the last word
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [glc_pkg::ROW_W-1:0] mask;
        logic                      last;
        logic                      drain;   // hold this row until every label word is back
    } t_row_word;

    typedef struct packed {
        logic [glc_pkg::NIDX_W-1:0] node;
        logic [glc_pkg::LBL_W-1:0]  lbl;
        logic                       no_sol;
        logic                       last_res;
    } t_label_word;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [glc_pkg::S_TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic                          i_s_axis_tlast  = 1'b0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [glc_pkg::M_TDATA_W-1:0] o_m_axis_tdata;
    logic                          o_m_axis_tlast;
    logic [0:0]                    o_m_axis_tuser;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [glc_pkg::LBL_W-1:0]     i_cfg_data      = '0;

    greedy_conflict_labeler uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_row_word   row_feed[$];
    t_label_word label_expect[$];

    // mirror of the block's state
    logic [glc_pkg::ROW_W-1:0] held_rows   [glc_pkg::NODES];
    logic [glc_pkg::LBL_W-1:0] held_labels [glc_pkg::NODES];
    int                        rows_held   = 0;
    logic [glc_pkg::LBL_W-1:0] label_limit = glc_pkg::MAX_LABELS_RST;

    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    bit  row_taken       = 1'b0;
    int  quiet_cycles    = 0;
    int  mismatches      = 0;
    int  matrices_done   = 0;
    int  over_limit_runs = 0;
    int  words_checked   = 0;
    int  limits_written  = 0;

    // Store one row; on the final row label the held matrix greedily and
    // queue the label words, or the single no-solution word.
    task automatic label_matrix(input logic [glc_pkg::ROW_W-1:0] mask, input logic last);
        int n;
        int fresh;
        int lab;
        bit failed;
        bit clash;
        if (rows_held < glc_pkg::NODES) begin
            held_rows[rows_held] = mask;
            rows_held++;
        end
        if (last) begin
            n      = rows_held;
            fresh  = 1;
            failed = 1'b0;
            for (int i = 0; i < n && !failed; i++) begin
                lab = fresh;
                // nodes flagged in row 0 always open a new label
                if (!held_rows[0][i]) begin
                    // scan down so the smallest free label wins
                    for (int cand = fresh - 1; cand >= 1; cand--) begin
                        clash = 1'b0;
                        for (int k = 0; k < i; k++)
                            if (held_labels[k] == cand && held_rows[i][k])
                                clash = 1'b1;
                        if (!clash)
                            lab = cand;
                    end
                end
                if (lab == fresh) begin
                    if (lab > int'(label_limit))
                        failed = 1'b1;
                    else
                        fresh++;
                end
                if (!failed)
                    held_labels[i] = glc_pkg::LBL_W'(lab);
            end
            rows_held = 0;
            matrices_done++;
            if (failed) begin
                over_limit_runs++;
                label_expect.push_back({glc_pkg::NIDX_W'(0), glc_pkg::LBL_W'(0),
                                        1'b1, 1'b1});
            end else begin
                for (int i = 0; i < n; i++)
                    label_expect.push_back({glc_pkg::NIDX_W'(i), held_labels[i],
                                            1'b0, (i == n - 1)});
            end
        end
    endtask

    // Row driver: advance on acceptance, hold while stalled, idle at random or while a drain row waits.
    always @(negedge i_clk) begin : feed_rows
        t_row_word nxt;
        logic      hold;
        hold      = i_s_axis_tvalid && !row_taken;
        row_taken = 1'b0;
        if (!i_rst_n || hold) begin
            // keep the current word on the bus
        end else if (row_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
                     (!row_feed[0].drain || label_expect.size() == 0)) begin
            nxt = row_feed.pop_front();
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= nxt.mask;
            i_s_axis_tlast  <= nxt.last;
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Sample both channels, check label words, watch for a hang.
    always @(posedge i_clk) begin : watch_ports
        t_label_word got;
        t_label_word want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                row_taken = 1'b1;
                label_matrix(i_s_axis_tdata[glc_pkg::ROW_W-1:0], i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata[glc_pkg::NIDX_W-1:0],
                       o_m_axis_tdata[glc_pkg::NIDX_W +: glc_pkg::LBL_W],
                       o_m_axis_tuser[0], o_m_axis_tlast};
                words_checked++;
                if (label_expect.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected label word node=%0d label=%0d %s",
                                 $realtime, got.node, got.lbl,
                                 $sformatf("nosol=%b last=%b", got.no_sol, got.last_res));
                    mismatches++;
                end else begin
                    want = label_expect.pop_front();
                    if (got.node !== want.node || got.lbl !== want.lbl ||
                        got.no_sol !== want.no_sol || got.last_res !== want.last_res) begin
                        if (mismatches < 10) begin
                            $display("%0t: label word mismatch exp node=%0d label=%0d %s",
                                     $realtime, want.node, want.lbl,
                                     $sformatf("nosol=%b last=%b", want.no_sol,
                                               want.last_res));
                            $display("%0t:                     got node=%0d label=%0d %s",
                                     $realtime, got.node, got.lbl,
                                     $sformatf("nosol=%b last=%b", got.no_sol,
                                               got.last_res));
                        end
                        mismatches++;
                    end
                end
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Wait until every row is in and every label word is back, then let the
    // sequencer drop back to row loading.
    task automatic settle();
        while (row_feed.size() != 0 || i_s_axis_tvalid || label_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_label_limit(input logic [glc_pkg::LBL_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        label_limit = value;
        limits_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed matrices of random size and density, some stray rows.
    task automatic queue_random(input int items);
        int                        added;
        int                        runs;
        int                        n;
        int                        pick;
        int                        density;
        logic [glc_pkg::ROW_W-1:0] m;
        added = 0;
        runs  = 0;
        while (added < items) begin
            if ($urandom_range(9) == 0) begin
                row_feed.push_back({glc_pkg::ROW_W'($urandom), 1'($urandom_range(1)), 1'b0});
                added++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 70)
                    n = $urandom_range(1, 8);
                else if (pick < 92)
                    n = $urandom_range(9, glc_pkg::NODES);
                else
                    // spill past the row store
                    n = $urandom_range(glc_pkg::NODES + 1, glc_pkg::NODES + 3);
                density = $urandom_range(3);
                for (int r = 0; r < n; r++) begin
                    case (density)
                        0: m = glc_pkg::ROW_W'($urandom);
                        1: m = glc_pkg::ROW_W'($urandom & $urandom & $urandom);
                        2: m = glc_pkg::ROW_W'($urandom | $urandom);
                        default: begin
                            pick = $urandom_range(2);
                            m = (pick == 0) ? '0 : (pick == 1) ? '1 :
                                glc_pkg::ROW_W'(1) << $urandom_range(glc_pkg::ROW_W - 1);
                        end
                    endcase
                    row_feed.push_back({m, (r == n - 1),
                                        (r == 0 && (runs == 2 || $urandom_range(14) == 0))});
                    added++;
                end
                runs++;
            end
        end
    endtask

    task automatic run_phase(input logic [glc_pkg::LBL_W-1:0] lim, input int idle_pct,
                             input int stall_pct, input int items);
        settle();
        write_label_limit(lim);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        queue_random(items);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed matrices under the reset label limit
        row_feed.push_back({16'h0000, 1'b1, 1'b0});   // lone node, no conflicts
        row_feed.push_back({16'hFFFF, 1'b1, 1'b0});   // lone node forced onto a new label
        // complete graph, one row past the store: the spare row is dropped
        // and the fifth node runs out of labels
        row_feed.push_back({16'h0000, 1'b0, 1'b0});
        for (int r = 1; r < glc_pkg::NODES + 1; r++)
            row_feed.push_back({16'hFFFF, (r == glc_pkg::NODES), 1'b0});
        row_feed.push_back({16'h0002, 1'b0, 1'b0});   // row 0 forces node 1 onto label 2
        row_feed.push_back({16'h0001, 1'b1, 1'b0});
        row_feed.push_back({16'h0000, 1'b0, 1'b0});   // path: node 2 reuses label 1
        row_feed.push_back({16'h0001, 1'b0, 1'b0});
        row_feed.push_back({16'h0002, 1'b1, 1'b0});

        run_phase(glc_pkg::LBL_W'(16), 0, 0, 50);
        run_phase(glc_pkg::LBL_W'(1), 85, 0, 40);
        run_phase(glc_pkg::LBL_W'(31), 0, 85, 40);
        run_phase(glc_pkg::LBL_W'(0), 35, 35, 20);
        run_phase(glc_pkg::LBL_W'($urandom_range(2, 15)), 35, 35, 50);

        settle();
        $display("Labeled %0d matrices (%0d over the limit), %0d label words checked,",
                 matrices_done, over_limit_runs, words_checked);
        $display("%0d limit writes, idle and stall phases on both sides", limits_written);
        if (mismatches == 0 && label_expect.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/glc_pkg.sv
src/glc_useq.sv
src/glc_dpath.sv
src/greedy_conflict_labeler.sv
dv/greedy_conflict_labeler_tb.sv
